// File: design/csft_pkg.sv
// Shared constants, types and arithmetic helpers of the clip-space frustum test.
package csft_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int DEPTH     = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int VEC_N     = 4;
  localparam int VIDX_W    = $clog2(VEC_N);
  localparam int PROD_W    = 2 * WORD_W;
  localparam int ACC_W     = WORD_W + VIDX_W;

  localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

  localparam logic [ADDR_W-1:0] LAST_CNT = ADDR_W'(DEPTH - 1);
  localparam logic [VIDX_W-1:0] LAST_COL = VIDX_W'(VEC_N - 1);
  localparam logic [VIDX_W-1:0] W_IDX    = VIDX_W'(VEC_N - 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_CMP
  } state_e;

  function automatic logic signed [WORD_W-1:0] sat_word(logic signed [PROD_W-1:0] v);
    logic [PROD_W-WORD_W:0] hi;
    hi = v[PROD_W-1:WORD_W-1];
    if (&hi || ~|hi) begin
      return v[WORD_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  function automatic logic in_rng(logic signed [WORD_W-1:0] c, logic signed [WORD_W-1:0] w);
    logic signed [WORD_W:0] ce;
    logic signed [WORD_W:0] wp;
    logic signed [WORD_W:0] wn;
    ce = (WORD_W+1)'(c);
    wp = (WORD_W+1)'(w);
    wn = -wp;
    if (w[WORD_W-1]) begin
      return (ce >= wp) && (ce < wn);
    end else begin
      return (ce > wn) && (ce <= wp);
    end
  endfunction

endpackage

// File: design/csft_req_if.sv
// Request channel: matrix loads and vertex tests.
interface csft_req_if import csft_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [ADDR_W-1:0]        entry_index;
  logic signed [WORD_W-1:0] entry_value;
  logic signed [WORD_W-1:0] point_x;
  logic signed [WORD_W-1:0] point_y;
  logic signed [WORD_W-1:0] point_z;

  modport source (
    output valid, cmd, entry_index, entry_value, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, entry_value, point_x, point_y, point_z,
    output ready
  );
endinterface

// File: design/csft_rsp_if.sv
// Response channel: frustum test verdicts.
interface csft_rsp_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic w_zero;

  modport source (output valid, inside_res, w_zero, input ready);
  modport sink (input valid, inside_res, w_zero, output ready);
endinterface

// File: design/clip_space_frustum_test_core.sv
// Clip-space frustum test: matrix store, shared multiply-accumulate and verdict.
//
//   channel  dir  handshake            payload
//   req_i    in   valid/ready          cmd, entry_index, entry_value, point_x/y/z
//   rsp_o    out  valid/ready          inside_res, w_zero
//
// A load beat writes the matrix store and returns nothing.
// A test beat: one multiplier forms 32 products in sequence (view rows, then
// projection rows), then a compare step forms the verdict.
// Reset restores identity matrices at once through per-entry valid bits.
// The output register holds a verdict while rsp_o stalls; the next beat is taken
// meanwhile, and a new verdict waits in the compare step until the register frees.
module clip_space_frustum_test_core import csft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  csft_req_if.sink   req_i,
  csft_rsp_if.source rsp_o
);

  state_e state_q, state_d;

  logic                     req_acc;
  logic                     issue;
  logic                     out_load;
  logic [ADDR_W-1:0]        cnt_q, cnt_d;
  logic signed [WORD_W-1:0] px_q, py_q, pz_q;
  logic [DEPTH-1:0]         ent_vld_q;

  logic [ADDR_W-1:0]        raddr;
  logic [WORD_W-1:0]        rdata;

  logic                     s1_vld_q;
  logic [ADDR_W-1:0]        s1_cnt_q;
  logic                     s1_ent_vld_q;
  logic signed [WORD_W-1:0] op_a;
  logic signed [WORD_W-1:0] op_b;

  logic                     s2_vld_q;
  logic [ADDR_W-1:0]        s2_cnt_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [WORD_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_q, acc_sum;
  logic signed [WORD_W-1:0] row_res;

  logic signed [WORD_W-1:0] ev_q [VEC_N];
  logic signed [WORD_W-1:0] cv_q [VEC_N];

  logic out_vld_q, inside_q, wzero_q;
  logic wz, in_view;

  assign req_acc = req_i.valid && req_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc && req_i.cmd == CMD_TEST) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_q == LAST_CNT) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (s2_vld_q && s2_cnt_q == LAST_CNT) state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!out_vld_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_i.ready = 1'b0;
    issue       = 1'b0;
    out_load    = 1'b0;
    cnt_d       = cnt_q;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        cnt_d       = '0;
      end
      ST_RUN: begin
        issue = 1'b1;
        cnt_d = cnt_q + ADDR_W'(1);
      end
      ST_DRAIN: ;
      ST_CMP: begin
        out_load = !out_vld_q || rsp_o.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      ent_vld_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (req_acc && req_i.cmd == CMD_LOAD) begin
        ent_vld_q[req_i.entry_index] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // matrix store; address is {matrix, column, row}
  assign raddr = {cnt_q[ADDR_W-1], cnt_q[VIDX_W-1:0], cnt_q[2*VIDX_W-1:VIDX_W]};

  csft_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (req_acc && req_i.cmd == CMD_LOAD),
    .waddr_i (req_i.entry_index),
    .wdata_i (req_i.entry_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // operand selection
  always_comb begin
    if (s1_ent_vld_q) begin
      op_a = rdata;
    end else if (s1_cnt_q[VIDX_W-1:0] == s1_cnt_q[2*VIDX_W-1:VIDX_W]) begin
      op_a = ONE_Q;
    end else begin
      op_a = '0;
    end
    if (s1_cnt_q[ADDR_W-1]) begin
      op_b = ev_q[s1_cnt_q[VIDX_W-1:0]];
    end else begin
      case (s1_cnt_q[VIDX_W-1:0])
        2'd0:    op_b = px_q;
        2'd1:    op_b = py_q;
        2'd2:    op_b = pz_q;
        default: op_b = ONE_Q;
      endcase
    end
  end

  // accumulate
  assign prod_shr = prod_q >>> FRAC_BITS;
  assign term     = sat_word(prod_shr);
  assign acc_sum  = ((s2_cnt_q[VIDX_W-1:0] == '0) ? ACC_W'(0) : acc_q) + ACC_W'(term);
  assign row_res  = sat_word(PROD_W'(acc_sum));

  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.cmd == CMD_TEST) begin
      px_q <= req_i.point_x;
      py_q <= req_i.point_y;
      pz_q <= req_i.point_z;
    end
    s1_cnt_q     <= cnt_q;
    s1_ent_vld_q <= ent_vld_q[raddr];
    s2_cnt_q     <= s1_cnt_q;
    prod_q       <= PROD_W'(op_a) * PROD_W'(op_b);
    if (s2_vld_q) begin
      acc_q <= acc_sum;
      if (s2_cnt_q[VIDX_W-1:0] == LAST_COL) begin
        if (s2_cnt_q[ADDR_W-1]) begin
          cv_q[s2_cnt_q[2*VIDX_W-1:VIDX_W]] <= row_res;
        end else begin
          ev_q[s2_cnt_q[2*VIDX_W-1:VIDX_W]] <= row_res;
        end
      end
    end
    if (out_load) begin
      inside_q <= in_view;
      wzero_q  <= wz;
    end
  end

  // verdict
  assign wz      = (cv_q[W_IDX] == '0);
  assign in_view = !wz && in_rng(cv_q[0], cv_q[W_IDX]) && in_rng(cv_q[1], cv_q[W_IDX])
                   && in_rng(cv_q[2], cv_q[W_IDX]);

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.inside_res = inside_q;
  assign rsp_o.w_zero     = wzero_q;

`ifndef NO_ASSERTIONS
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && s2_vld_q && s2_cnt_q == LAST_CNT) |=> state_q == ST_CMP)
    else $error("last product did not lead to compare");

  a_verdict_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.inside_res && rsp_o.w_zero))
    else $error("inside reported with zero w");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q != LAST_CNT) |=> cnt_q == $past(cnt_q) + ADDR_W'(1))
    else $error("issue counter skipped");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_CMP)
    else $error("verdict without compare step");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q || s2_vld_q) |-> !req_i.ready)
    else $error("request taken while products in flight");
`endif

endmodule

// File: design/csft_ram.sv
// Generic single-port-write, registered-read RAM.
module csft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: tb/sv/clip_space_frustum_test_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the clip-space frustum test core.
module clip_space_frustum_test_core_tb;
  import csft_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned QUIET_LIMIT     = 3000;

  localparam logic signed [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic in_view;
    logic w_zero;
  } verdict_t;

  typedef longint vec_t[VEC_N];

  class frustum_scoreboard;
    logic signed [WORD_W-1:0] matrix[DEPTH];
    verdict_t                 verdict_q[$];
    int unsigned              failures;

    function new();
      failures = 0;
      for (int i = 0; i < DEPTH; i++) begin
        matrix[i] = '0;
      end
      for (int i = 0; i < VEC_N; i++) begin
        matrix[i * 5]           = ONE_Q;
        matrix[DEPTH / 2 + i * 5] = ONE_Q;
      end
    endfunction

    function longint saturate(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function longint fixed_mul(longint a, longint b);
      return saturate((a * b) >>> FRAC_BITS);
    endfunction

    function void apply_matrix(int base, input vec_t vin, output vec_t vout);
      longint acc;
      for (int r = 0; r < VEC_N; r++) begin
        acc = 0;
        for (int c = 0; c < VEC_N; c++) begin
          acc += fixed_mul(longint'(matrix[base + VEC_N * c + r]), vin[c]);
        end
        vout[r] = saturate(acc);
      end
    endfunction

    function bit in_bounds(longint c, longint w);
      if (w > 0) return (c > -w) && (c <= w);
      return (c >= w) && (c < -w);
    endfunction

    function void note_beat(logic cmd, logic [ADDR_W-1:0] idx,
                            logic signed [WORD_W-1:0] val, logic signed [WORD_W-1:0] px,
                            logic signed [WORD_W-1:0] py, logic signed [WORD_W-1:0] pz);
      vec_t     pt;
      vec_t     eye;
      vec_t     clip;
      verdict_t v;
      if (cmd == CMD_LOAD) begin
        matrix[idx] = val;
        return;
      end
      pt[0] = longint'(px);
      pt[1] = longint'(py);
      pt[2] = longint'(pz);
      pt[3] = longint'(ONE_Q);
      apply_matrix(0, pt, eye);
      apply_matrix(DEPTH / 2, eye, clip);
      v.w_zero  = (clip[W_IDX] == 0);
      v.in_view = !v.w_zero && in_bounds(clip[0], clip[W_IDX]) &&
                  in_bounds(clip[1], clip[W_IDX]) && in_bounds(clip[2], clip[W_IDX]);
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(logic in_view, logic w_zero);
      verdict_t exp_v;
      if (verdict_q.size() == 0) begin
        $error("verdict beat with no test pending: inside_res %0b, w_zero %0b",
               in_view, w_zero);
        failures++;
        return;
      end
      exp_v = verdict_q.pop_front();
      if (in_view !== exp_v.in_view) begin
        $error("inside_res mismatch: expected %0b, actual %0b", exp_v.in_view, in_view);
        failures++;
      end
      if (w_zero !== exp_v.w_zero) begin
        $error("w_zero mismatch: expected %0b, actual %0b", exp_v.w_zero, w_zero);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  csft_req_if req_if ();
  csft_rsp_if rsp_if ();

  clip_space_frustum_test_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  frustum_scoreboard        sb;
  logic signed [WORD_W-1:0] scene_word[DEPTH];
  int unsigned              items_sent;
  int unsigned              send_idle_pct;
  int unsigned              recv_stall_pct;
  int unsigned              quiet_cycles;
  bit                       hold_req;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_verdict(rsp_if.inside_res, rsp_if.w_zero);
      end
      if (req_if.valid && req_if.ready) begin
        sb.note_beat(req_if.cmd, req_if.entry_index, req_if.entry_value,
                     req_if.point_x, req_if.point_y, req_if.point_z);
      end
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("clip_space_frustum_test_core regression: fail");
    $finish;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic signed [WORD_W-1:0] rand_q(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return rand_q(2 * ONE_Q);
    if (pick < 70) return rand_q(16 * ONE_Q);
    if (pick < 85) begin
      if ($urandom_range(9) == 0) return '0;
      return ($urandom_range(1) ? ONE_Q : -ONE_Q) + int'($urandom_range(2)) - 1;
    end
    return $urandom();
  endfunction

  task automatic build_scene();
    int unsigned mode;
    for (int i = 0; i < DEPTH; i++) begin
      scene_word[i] = '0;
    end
    mode = $urandom_range(99);
    if (mode < 15) begin
      for (int i = 0; i < VEC_N; i++) begin
        scene_word[i * 5]             = ONE_Q;
        scene_word[DEPTH / 2 + i * 5] = ONE_Q;
      end
      case ($urandom_range(2))
        0: scene_word[DEPTH - 1] = -ONE_Q;
        1: scene_word[DEPTH - 1] = '0;
        default: scene_word[DEPTH - 1] = ONE_Q;
      endcase
      return;
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        scene_word[VEC_N * c + r] = rand_q(ONE_Q);
      end
      scene_word[12 + c] = rand_q(8 * ONE_Q);
    end
    scene_word[15] = ONE_Q;
    if (mode < 30) begin
      scene_word[16] = $urandom_range(ONE_Q / 20, ONE_Q / 2);
      scene_word[21] = $urandom_range(ONE_Q / 20, ONE_Q / 2);
      scene_word[26] = -int'($urandom_range(ONE_Q / 20, ONE_Q / 2));
      scene_word[30] = rand_q(ONE_Q);
      scene_word[31] = ONE_Q;
    end else begin
      scene_word[16] = $urandom_range(ONE_Q / 2, 3 * ONE_Q);
      scene_word[21] = $urandom_range(ONE_Q / 2, 3 * ONE_Q);
      scene_word[26] = -int'($urandom_range(ONE_Q, ONE_Q + ONE_Q / 2));
      scene_word[27] = -ONE_Q;
      scene_word[30] = -int'($urandom_range(ONE_Q / 10, 2 * ONE_Q));
    end
  endtask

  task automatic send_beat(logic cmd, logic [ADDR_W-1:0] idx, logic signed [WORD_W-1:0] val,
                           logic signed [WORD_W-1:0] px, logic signed [WORD_W-1:0] py,
                           logic signed [WORD_W-1:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= cmd;
    req_if.entry_index <= idx;
    req_if.entry_value <= val;
    req_if.point_x     <= px;
    req_if.point_y     <= py;
    req_if.point_z     <= pz;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_load(logic [ADDR_W-1:0] idx, logic signed [WORD_W-1:0] val);
    send_beat(CMD_LOAD, idx, val, $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_test(logic signed [WORD_W-1:0] px, logic signed [WORD_W-1:0] py,
                           logic signed [WORD_W-1:0] pz);
    send_beat(CMD_TEST, ADDR_W'($urandom_range(DEPTH - 1)), $urandom(), px, py, pz);
  endtask

  task automatic run_traffic(int unsigned n_items);
    int unsigned      stop_at;
    int unsigned      pick;
    logic [ADDR_W-1:0] idx;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        build_scene();
        for (int i = 0; i < DEPTH; i++) begin
          send_load(ADDR_W'(i), scene_word[i]);
        end
      end else if (pick < 70) begin
        build_scene();
        repeat ($urandom_range(4)) begin
          idx = ADDR_W'($urandom_range(DEPTH - 1));
          send_load(idx, scene_word[idx]);
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_load(ADDR_W'($urandom_range(DEPTH - 1)), $urandom());
        end
      end
      repeat ($urandom_range(1, 8)) begin
        send_test(rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    int unsigned idle_tbl[4];
    int unsigned stall_tbl[4];
    idle_tbl  = '{0, 59, 0, 13};
    stall_tbl = '{0, 0, 59, 13};
    sb             = new();
    items_sent     = 0;
    quiet_cycles   = 0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.cmd         <= CMD_LOAD;
    req_if.entry_index <= '0;
    req_if.entry_value <= '0;
    req_if.point_x     <= '0;
    req_if.point_y     <= '0;
    req_if.point_z     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_test('0, '0, '0);
    send_test(ONE_Q, ONE_Q, ONE_Q);
    send_test(-ONE_Q, '0, '0);
    send_test(-ONE_Q + 1, -ONE_Q + 1, -ONE_Q + 1);
    send_test(ONE_Q + 1, '0, '0);
    send_test(Q_MAX, Q_MIN, Q_MAX);
    send_load(ADDR_W'(DEPTH - 1), -ONE_Q);
    send_test(-ONE_Q, -ONE_Q, -ONE_Q);
    send_test(ONE_Q, '0, '0);
    send_test(ONE_Q - 1, '0, '0);
    send_load(ADDR_W'(DEPTH - 1), '0);
    send_test('0, '0, '0);
    send_load(ADDR_W'(DEPTH - 1), ONE_Q);
    send_load(ADDR_W'(0), Q_MAX);
    send_load(ADDR_W'(5), Q_MIN);
    send_test(Q_MAX, Q_MAX, Q_MIN);
    send_test(Q_MIN, Q_MIN, Q_MAX);
    send_load(ADDR_W'(0), ONE_Q);
    send_load(ADDR_W'(5), ONE_Q);
    send_load(ADDR_W'(DEPTH / 2), Q_MIN);
    send_test(ONE_Q, '0, '0);
    send_load(ADDR_W'(DEPTH / 2), ONE_Q);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tbl[ph];
      recv_stall_pct = stall_tbl[ph];
      if (ph == 0) hold_req = 1'b1;
      run_traffic(ITEMS_PER_PHASE);
    end
    req_if.valid <= 1'b0;

    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("clip_space_frustum_test_core regression: pass");
    end else begin
      $display("clip_space_frustum_test_core regression: fail");
    end
    $finish;
  end

endmodule
